@@ design/icp_pkg.sv @@
package icp_pkg;

  localparam logic [2:0] PH_LEAD    = 3'd0;
  localparam logic [2:0] PH_KEYWORD = 3'd1;
  localparam logic [2:0] PH_ALL     = 3'd2;
  localparam logic [2:0] PH_OCTET   = 3'd3;
  localparam logic [2:0] PH_PREFIX  = 3'd4;
  localparam logic [2:0] PH_TRAIL   = 3'd5;
  localparam logic [2:0] PH_ERROR   = 3'd6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [8:0] OCTET_MAX  = 9'd255;
  localparam logic [5:0] PREFIX_MAX = 6'd32;

  localparam logic [7:0] KEYWORD [3] = '{8'h61, 8'h6C, 8'h6C};

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [31:0] mask_of(input logic [5:0] p);
    logic [5:0] pc;
    pc = (p > PREFIX_MAX) ? PREFIX_MAX : p;
    if (pc == 6'd0) begin
      mask_of = 32'd0;
    end else begin
      mask_of = 32'hFFFF_FFFF << (6'd32 - pc);
    end
  endfunction

endpackage

@@ design/ipv4_cidr_text_parser.sv @@
// IPv4 CIDR text parser. Feed one ASCII character per request on in_ch; a NUL
// ends the text and yields exactly one result (ok, network, mask, pfx_len),
// other characters yield none. Accepted forms: optional leading whitespace,
// then the case-insensitive keyword "all" (network 0, mask 0, prefix 0) or four
// dotted decimal octets without leading zeros, optional "/0".."/32", then only
// whitespace. On any format error ok is 0 and the other fields are 0. One
// character is taken every cycle unless in_stall is high; the parse state
// updates in the accepting cycle and the verdict sits in an output register in
// the cycle after the NUL is accepted. in_stall rises only when in_ch holds a NUL
// while an undelivered result is held by out_stall. cfg_data sets address-only
// mode (keyword and slash rejected); write it between texts. cfg_ready is always high.
module ipv4_cidr_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [31:0] out_network,
  output logic [31:0] out_mask,
  output logic [5:0]  out_pfx_len
);

  logic        addr_only_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  oidx_r, oidx_nxt;
  logic [8:0]  oval_r, oval_nxt;
  logic [1:0]  odig_r, odig_nxt;
  logic        olz_r, olz_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [5:0]  pval_r, pval_nxt;
  logic        pseen_r, pseen_nxt;
  logic [1:0]  kcnt_r, kcnt_nxt;

  logic        ovld_r, ovld_nxt;
  logic        ook_r, ook_nxt;
  logic [31:0] onet_r, onet_nxt;
  logic [31:0] omask_r, omask_nxt;
  logic [5:0]  opl_r, opl_nxt;

  logic        in_acc;
  logic        nul;
  logic        sp;
  logic        dig;
  logic [3:0]  dval;
  logic [7:0]  lc;
  logic        close_ok;
  logic [31:0] addr_close;
  logic [11:0] oval_calc;
  logic [9:0]  pval_calc;
  logic        res_ok;
  logic        res_all;
  logic [5:0]  res_pl;
  logic [31:0] res_mask;
  logic [31:0] res_addr;

  assign cfg_ready = 1'b1;
  assign in_stall  = ovld_r & out_stall & (in_ch == icp_pkg::CH_NUL);
  assign in_acc    = in_valid & ~in_stall;
  assign nul       = (in_ch == icp_pkg::CH_NUL);
  assign sp        = icp_pkg::is_space(in_ch);
  assign dig       = icp_pkg::is_digit(in_ch);
  assign dval      = in_ch[3:0];
  assign lc        = in_ch | icp_pkg::CASE_BIT;

  assign close_ok   = (odig_r != 2'd0) && (oidx_r == 2'd3) && (oval_r <= icp_pkg::OCTET_MAX);
  assign addr_close = {addr_r[23:0], oval_r[7:0]};
  assign oval_calc  = ({3'd0, oval_r} * 12'd10) + {8'd0, dval};
  assign pval_calc  = ({4'd0, pval_r} * 10'd10) + {6'd0, dval};

  always_comb begin
    phase_nxt = phase_r;
    oidx_nxt  = oidx_r;
    oval_nxt  = oval_r;
    odig_nxt  = odig_r;
    olz_nxt   = olz_r;
    addr_nxt  = addr_r;
    pval_nxt  = pval_r;
    pseen_nxt = pseen_r;
    kcnt_nxt  = kcnt_r;
    res_ok    = 1'b0;
    res_all   = 1'b0;
    res_pl    = pval_r;
    res_addr  = addr_r;

    if (nul) begin
      unique case (phase_r)
        icp_pkg::PH_ALL: begin
          res_ok  = 1'b1;
          res_all = 1'b1;
        end
        icp_pkg::PH_OCTET: begin
          res_ok   = close_ok;
          res_pl   = icp_pkg::PREFIX_MAX;
          res_addr = addr_close;
        end
        icp_pkg::PH_PREFIX: res_ok = pseen_r && (pval_r <= icp_pkg::PREFIX_MAX);
        icp_pkg::PH_TRAIL:  res_ok = 1'b1;
        default:            res_ok = 1'b0;
      endcase
      phase_nxt = icp_pkg::PH_LEAD;
      oidx_nxt  = 2'd0;
      oval_nxt  = 9'd0;
      odig_nxt  = 2'd0;
      olz_nxt   = 1'b0;
      addr_nxt  = 32'd0;
      pval_nxt  = 6'd0;
      pseen_nxt = 1'b0;
      kcnt_nxt  = 2'd0;
    end else if ((phase_r == icp_pkg::PH_OCTET) ||
                 ((phase_r == icp_pkg::PH_LEAD) && dig)) begin
      phase_nxt = icp_pkg::PH_OCTET;
      if (dig) begin
        if ((odig_r != 2'd0) && olz_r) begin
          phase_nxt = icp_pkg::PH_ERROR;
        end else begin
          if (odig_r == 2'd0) begin
            olz_nxt = (dval == 4'd0);
          end
          oval_nxt = (oval_calc > 12'd256) ? 9'd256 : oval_calc[8:0];
          if (odig_r < 2'd2) begin
            odig_nxt = odig_r + 2'd1;
          end
        end
      end else if (in_ch == icp_pkg::CH_DOT) begin
        if ((odig_r == 2'd0) || (oidx_r == 2'd3) || (oval_r > icp_pkg::OCTET_MAX)) begin
          phase_nxt = icp_pkg::PH_ERROR;
        end else begin
          addr_nxt = addr_close;
          oidx_nxt = oidx_r + 2'd1;
          oval_nxt = 9'd0;
          odig_nxt = 2'd0;
          olz_nxt  = 1'b0;
        end
      end else if (in_ch == icp_pkg::CH_SLASH) begin
        if (addr_only_r || !close_ok) begin
          phase_nxt = icp_pkg::PH_ERROR;
        end else begin
          addr_nxt  = addr_close;
          pval_nxt  = 6'd0;
          pseen_nxt = 1'b0;
          phase_nxt = icp_pkg::PH_PREFIX;
        end
      end else if (sp) begin
        if (!close_ok) begin
          phase_nxt = icp_pkg::PH_ERROR;
        end else begin
          addr_nxt  = addr_close;
          pval_nxt  = icp_pkg::PREFIX_MAX;
          phase_nxt = icp_pkg::PH_TRAIL;
        end
      end else begin
        phase_nxt = icp_pkg::PH_ERROR;
      end
    end else begin
      unique case (phase_r)
        icp_pkg::PH_LEAD: begin
          if (sp) begin
            phase_nxt = icp_pkg::PH_LEAD;
          end else if (!addr_only_r && (lc == icp_pkg::KEYWORD[0])) begin
            kcnt_nxt  = 2'd1;
            phase_nxt = icp_pkg::PH_KEYWORD;
          end else begin
            phase_nxt = icp_pkg::PH_ERROR;
          end
        end
        icp_pkg::PH_KEYWORD: begin
          if ((kcnt_r != 2'd3) && (lc == icp_pkg::KEYWORD[kcnt_r])) begin
            kcnt_nxt = kcnt_r + 2'd1;
            if (kcnt_r == 2'd2) begin
              phase_nxt = icp_pkg::PH_ALL;
            end
          end else begin
            phase_nxt = icp_pkg::PH_ERROR;
          end
        end
        icp_pkg::PH_ALL, icp_pkg::PH_TRAIL: begin
          if (!sp) begin
            phase_nxt = icp_pkg::PH_ERROR;
          end
        end
        icp_pkg::PH_PREFIX: begin
          if (dig) begin
            pval_nxt  = (pval_calc > 10'd33) ? 6'd33 : pval_calc[5:0];
            pseen_nxt = 1'b1;
          end else if (sp && pseen_r && (pval_r <= icp_pkg::PREFIX_MAX)) begin
            phase_nxt = icp_pkg::PH_TRAIL;
          end else begin
            phase_nxt = icp_pkg::PH_ERROR;
          end
        end
        default: phase_nxt = icp_pkg::PH_ERROR;
      endcase
    end
  end

  assign res_mask = icp_pkg::mask_of(res_pl);

  always_comb begin
    ovld_nxt  = ovld_r & out_stall;
    ook_nxt   = ook_r;
    onet_nxt  = onet_r;
    omask_nxt = omask_r;
    opl_nxt   = opl_r;
    if (in_acc && nul) begin
      ovld_nxt = 1'b1;
      ook_nxt  = res_ok;
      if (res_ok && !res_all) begin
        onet_nxt  = res_addr & res_mask;
        omask_nxt = res_mask;
        opl_nxt   = res_pl;
      end else begin
        onet_nxt  = 32'd0;
        omask_nxt = 32'd0;
        opl_nxt   = 6'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_only_r <= 1'b0;
      phase_r     <= icp_pkg::PH_LEAD;
      oidx_r      <= 2'd0;
      oval_r      <= 9'd0;
      odig_r      <= 2'd0;
      olz_r       <= 1'b0;
      addr_r      <= 32'd0;
      pval_r      <= 6'd0;
      pseen_r     <= 1'b0;
      kcnt_r      <= 2'd0;
      ovld_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        addr_only_r <= cfg_data;
      end
      if (in_acc) begin
        phase_r <= phase_nxt;
        oidx_r  <= oidx_nxt;
        oval_r  <= oval_nxt;
        odig_r  <= odig_nxt;
        olz_r   <= olz_nxt;
        addr_r  <= addr_nxt;
        pval_r  <= pval_nxt;
        pseen_r <= pseen_nxt;
        kcnt_r  <= kcnt_nxt;
      end
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ook_r   <= ook_nxt;
    onet_r  <= onet_nxt;
    omask_r <= omask_nxt;
    opl_r   <= opl_nxt;
  end

  assign out_valid   = ovld_r;
  assign out_ok      = ook_r;
  assign out_network = onet_r;
  assign out_mask    = omask_r;
  assign out_pfx_len = opl_r;

endmodule

@@ design/icp_checker.sv @@
module icp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_ch,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_ok,
  input logic [31:0] out_network,
  input logic [31:0] out_mask,
  input logic [5:0]  out_pfx_len
);

  a_nul_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_ch == icp_pkg::CH_NUL)) |=> out_valid)
    else $error("accepted NUL produced no result");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |->
      ((out_network == 32'd0) && (out_mask == 32'd0) && (out_pfx_len == 6'd0)))
    else $error("error result carries nonzero fields");

  a_network_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((out_network & ~out_mask) == 32'd0) &&
                   (out_pfx_len <= icp_pkg::PREFIX_MAX) &&
                   (out_mask == icp_pkg::mask_of(out_pfx_len))))
    else $error("network, mask and prefix disagree");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_ok) &&
                                  $stable(out_network) && $stable(out_pfx_len)))
    else $error("stalled result changed");

endmodule

bind ipv4_cidr_text_parser icp_checker u_icp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_ch       (in_ch),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_ok      (out_ok),
  .out_network (out_network),
  .out_mask    (out_mask),
  .out_pfx_len (out_pfx_len)
);
